@@ rtl/longest_common_subsequence_core_macros.svh @@
// Assertion macros used by the LCS controller RTL.
`ifndef LONGEST_COMMON_SUBSEQUENCE_CORE_MACROS_SVH
`define LONGEST_COMMON_SUBSEQUENCE_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define LCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define LCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lcs_pkg.sv @@
// Shared types and request codes for the LCS core.
`default_nettype none
package lcs_pkg;

  localparam int LEN_W  = 7;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REQ_LOAD_A = 2'd0,
    REQ_LOAD_B = 2'd1,
    REQ_RUN    = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic run_init;
    logic fill_wr;
    logic tb_ev;
    logic em_next;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic run_empty;
    logic row_end;
    logic last_row;
    logic tb_end;
    logic trace_empty;
    logic emit_last;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/lcs_datapath.sv @@
// LCS datapath: sequence stores, DP table, traceback buffer and counters.
`default_nettype none
module lcs_datapath #(
  parameter int MAX_LEN    = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire lcs_pkg::cmd_t                cmd,
  output lcs_pkg::sts_t                     sts,
  input  wire logic [lcs_pkg::DATA_W-1:0]   in_value,
  output logic      [lcs_pkg::LEN_W-1:0]    lcs_length,
  output logic      [lcs_pkg::DATA_W-1:0]   element,
  output logic                              element_valid,
  output logic                              overflow,
  output logic                              last
);
  import lcs_pkg::*;

  localparam int CW    = $clog2(MAX_LEN + 1);
  localparam int IW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DEPTH = MAX_LEN * MAX_LEN;
  localparam int DAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = ELEM_WIDTH;

  logic [EW-1:0] seq_a [MAX_LEN];
  logic [EW-1:0] seq_b [MAX_LEN];
  logic [EW-1:0] trace [MAX_LEN];
  logic [CW-1:0] dp    [DEPTH];

  logic [CW-1:0] cnt_a_r, cnt_b_r, i_r, j_r, tcnt_r, k_r, len_r;
  logic [CW-1:0] left_r, diag_r;
  logic          ovf_r;
  logic [EW-1:0] a_q, b_q, t_q;
  logic [CW-1:0] up_q, lf_q;

  logic signed [63:0] v64;
  logic [EW-1:0]      val_ext;
  logic [63:0]        t64;
  logic [2*CW-1:0]    cur_full, up_full, lf_full;
  logic [DAW-1:0]     cur_addr, up_addr, lf_addr;
  logic [CW-1:0]      ia, jb, ta, up_v, lf_v, lft, dg, dp_val;
  logic               match;

  always_comb begin
    v64      = 64'(signed'(in_value));
    val_ext  = v64[EW-1:0];
    ia       = i_r - 1'b1;
    jb       = j_r - 1'b1;
    ta       = tcnt_r - k_r - 1'b1;
    cur_full = (2*CW)'(ia) * (2*CW)'(MAX_LEN) + (2*CW)'(jb);
    up_full  = cur_full - (2*CW)'(MAX_LEN);
    lf_full  = cur_full - 1'b1;
    cur_addr = cur_full[DAW-1:0];
    up_addr  = up_full[DAW-1:0];
    lf_addr  = lf_full[DAW-1:0];
    match    = (a_q == b_q);
    up_v     = (i_r == 1) ? '0 : up_q;
    lf_v     = (j_r == 1) ? '0 : lf_q;
    lft      = (j_r == 1) ? '0 : left_r;
    dg       = (j_r == 1) ? '0 : diag_r;
    dp_val   = match ? dg + 1'b1 : ((up_v > lft) ? up_v : lft);
    t64      = 64'(t_q);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_a && cnt_a_r < CW'(MAX_LEN)) seq_a[cnt_a_r[IW-1:0]] <= val_ext;
    a_q <= seq_a[ia[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_b && cnt_b_r < CW'(MAX_LEN)) seq_b[cnt_b_r[IW-1:0]] <= val_ext;
    b_q <= seq_b[jb[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_wr) dp[cur_addr] <= dp_val;
    up_q <= dp[up_addr];
    lf_q <= dp[lf_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.tb_ev && match) trace[tcnt_r[IW-1:0]] <= a_q;
    t_q <= trace[ta[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.clear) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.load_a) begin
      if (cnt_a_r < CW'(MAX_LEN)) cnt_a_r <= cnt_a_r + 1'b1;
      else ovf_r <= 1'b1;
    end else if (cmd.load_b) begin
      if (cnt_b_r < CW'(MAX_LEN)) cnt_b_r <= cnt_b_r + 1'b1;
      else ovf_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      i_r    <= CW'(1);
      j_r    <= CW'(1);
      tcnt_r <= '0;
      k_r    <= '0;
      len_r  <= '0;
    end else if (cmd.fill_wr) begin
      left_r <= dp_val;
      diag_r <= up_v;
      if (j_r == cnt_b_r) begin
        if (i_r == cnt_a_r) len_r <= dp_val;
        else begin
          i_r <= i_r + 1'b1;
          j_r <= CW'(1);
        end
      end else begin
        j_r <= j_r + 1'b1;
      end
    end else if (cmd.tb_ev) begin
      if (match) begin
        tcnt_r <= tcnt_r + 1'b1;
        i_r    <= i_r - 1'b1;
        j_r    <= j_r - 1'b1;
      end else if (up_v > lf_v) begin
        i_r <= i_r - 1'b1;
      end else begin
        j_r <= j_r - 1'b1;
      end
    end else if (cmd.em_next) begin
      k_r <= k_r + 1'b1;
    end
  end

  always_comb begin
    sts.run_empty   = (cnt_a_r == 0) || (cnt_b_r == 0);
    sts.row_end     = (j_r == cnt_b_r);
    sts.last_row    = (i_r == cnt_a_r);
    sts.tb_end      = (i_r == 0) || (j_r == 0);
    sts.trace_empty = (tcnt_r == 0);
    sts.emit_last   = (k_r + 1'b1 == tcnt_r);
    lcs_length      = LEN_W'(len_r);
    element         = sts.trace_empty ? '0 : t64[DATA_W-1:0];
    element_valid   = !sts.trace_empty;
    overflow        = ovf_r;
    last            = sts.trace_empty || sts.emit_last;
  end

endmodule
`default_nettype wire

@@ rtl/lcs_ctrl.sv @@
// LCS controller: load, table fill, traceback and emit sequencing.
`default_nettype none
`include "longest_common_subsequence_core_macros.svh"
module lcs_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire lcs_pkg::req_t  in_req,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  input  wire logic           out_last,
  input  wire lcs_pkg::sts_t  sts,
  output lcs_pkg::cmd_t       cmd
);
  import lcs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_FILL_RD = 7'b0000010,
    S_FILL_WR = 7'b0000100,
    S_TB_RD   = 7'b0001000,
    S_TB_EV   = 7'b0010000,
    S_EM_RD   = 7'b0100000,
    S_EM_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = (state_r == S_IDLE);
    out_tvalid = (state_r == S_EM_OUT);
    in_acc     = in_tvalid && in_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_req)
            REQ_LOAD_A: cmd.load_a = 1'b1;
            REQ_LOAD_B: cmd.load_b = 1'b1;
            REQ_RUN: begin
              cmd.run_init = 1'b1;
              state_nxt    = sts.run_empty ? S_EM_OUT : S_FILL_RD;
            end
            default: ;
          endcase
        end
      end
      S_FILL_RD: state_nxt = S_FILL_WR;
      S_FILL_WR: begin
        cmd.fill_wr = 1'b1;
        state_nxt   = (sts.row_end && sts.last_row) ? S_TB_RD : S_FILL_RD;
      end
      S_TB_RD: begin
        if (sts.tb_end) state_nxt = sts.trace_empty ? S_EM_OUT : S_EM_RD;
        else            state_nxt = S_TB_EV;
      end
      S_TB_EV: begin
        cmd.tb_ev = 1'b1;
        state_nxt = S_TB_RD;
      end
      S_EM_RD: state_nxt = S_EM_OUT;
      S_EM_OUT: begin
        if (out_tready) begin
          if (out_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.em_next = 1'b1;
            state_nxt   = S_EM_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `LCS_ASSERT_NOW(a_no_overlap, out_tvalid, !in_tready, "input taken while emitting")
  `LCS_ASSERT_NEXT(a_run_busy, in_tvalid && in_tready && in_req == REQ_RUN, !in_tready, "run did not stall input")
  `LCS_ASSERT_NEXT(a_back_idle, out_tvalid && out_tready && out_last, in_tready, "no return to idle after last item")

endmodule
`default_nettype wire

@@ rtl/longest_common_subsequence_core.sv @@
// Top level of the longest-common-subsequence core.
//  channel | dir | tdata                      | tuser                       | tlast
//  in_     | in  | value[31:0]                | req_type[1:0]               | -
//  out_    | out | lcs_length[6:0],elem[38:7] | element_valid[0],overflow[1]| last
// A run does a DP memory read then write per table cell (n*m cells), then at
// most n+m traceback steps of a read and an evaluate state, then a read and an
// output state per result item plus any out_tready stall. Synchronous active-low
// reset clears counts and the overflow flag; stores are not cleared. No input is
// taken from a run request until its last result item is accepted.
`default_nettype none
module longest_common_subsequence_core #(
  parameter int MAX_LEN    = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // value[31:0]
  input  wire logic [1:0]  in_tuser,   // req_type[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // lcs_length[6:0], element[38:7], zero pad
  output logic [1:0]       out_tuser,  // element_valid[0], overflow[1]
  output logic             out_tlast
);
  import lcs_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [LEN_W-1:0]  len;
  logic [DATA_W-1:0] elem;
  logic              evalid, ovf, lst;

  lcs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_req     (req_t'(in_tuser)),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_last   (lst),
    .sts        (sts),
    .cmd        (cmd)
  );

  lcs_datapath #(
    .MAX_LEN    (MAX_LEN),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_value      (in_tdata),
    .lcs_length    (len),
    .element       (elem),
    .element_valid (evalid),
    .overflow      (ovf),
    .last          (lst)
  );

  assign out_tdata = {1'b0, elem, len};
  assign out_tuser = {ovf, evalid};
  assign out_tlast = lst;

endmodule
`default_nettype wire
